// ===== hw/rtl/rdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_W  = 32;  // width of the value field on the input word
    localparam int RADIX_W  = 5;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;
    localparam int DIV_STEP = 8;   // quotient bits resolved per divider cycle
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [DIGIT_W-1:0] DEC_BASE  = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } rdc_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic rd_issue;
    } rdc_cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic can_issue;
        logic rd_last;
    } rdc_stat_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_BASE);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rdc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rdc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix divider, digit stack and two-word output buffer.
// ----------------------------------------------------------------------------
module rdc_datapath
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire rdc_cmd_t               cmd,
    output rdc_stat_t                   stat,
    input  wire logic [VALUE_W-1:0]     in_value,
    input  wire logic [RADIX_W-1:0]     in_radix,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CHAR_W-1:0]           out_char,
    output logic                        out_last
);

    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_BITS   = DIV_CYCLES * DIV_STEP;
    localparam int IN_BITS    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int SW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CW         = $clog2(VALUE_BITS + 1);
    localparam int AW         = $clog2(VALUE_BITS);
    localparam int BUF_W      = CHAR_W + 1;

    logic [PAD_BITS-1:0] w_reg;
    logic [PAD_BITS-1:0] w_div;
    logic [RADIX_W-1:0]  radix_reg;
    logic [DIGIT_W-1:0]  rem_reg;
    logic [DIGIT_W-1:0]  rem_div;
    logic [SW-1:0]       step_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_dec;
    logic                pend_reg;
    logic                pend_last_reg;
    logic [1:0]          occ_reg;
    logic [1:0]          occ_next;
    logic [1:0]          occ_after_pop;
    logic [2:0]          level;
    logic [BUF_W-1:0]    head_reg;
    logic [BUF_W-1:0]    tail_reg;
    logic [BUF_W-1:0]    push_word;
    logic [DIGIT_W-1:0]  ram_rdata;
    logic                pop;

    // one divider cycle: DIV_STEP restoring steps on a remainder below the radix
    always_comb begin
        logic [DIGIT_W-1:0]  r;
        logic [RADIX_W-1:0]  t;
        logic [DIV_STEP-1:0] top;
        logic [DIV_STEP-1:0] q;
        r   = rem_reg;
        top = w_reg[PAD_BITS-1 -: DIV_STEP];
        q   = '0;
        for (int i = DIV_STEP - 1; i >= 0; i--) begin
            t = {r, top[i]};
            if (t >= radix_reg) begin
                t    = t - radix_reg;
                q[i] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_div = r;
        w_div   = (w_reg << DIV_STEP) | PAD_BITS'(q);
    end

    assign cnt_dec = cnt_reg - CW'(1);
    assign pop     = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg     <= PAD_BITS'(in_value[IN_BITS-1:0]);
            radix_reg <= clamp_radix(in_radix);
            rem_reg   <= '0;
        end else if (cmd.div_step) begin
            w_reg   <= w_div;
            rem_reg <= rem_div;
        end else if (cmd.store) begin
            rem_reg <= '0;
        end
        if (cmd.rd_issue) begin
            pend_last_reg <= stat.rd_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            occ_reg  <= '0;
        end else begin
            if (cmd.load) begin
                step_reg <= '0;
                cnt_reg  <= '0;
            end else if (cmd.div_step) begin
                step_reg <= step_reg + SW'(1);
            end else if (cmd.store) begin
                step_reg <= '0;
                cnt_reg  <= cnt_reg + CW'(1);
            end else if (cmd.rd_issue) begin
                cnt_reg <= cnt_dec;
            end
            pend_reg <= cmd.rd_issue;
            occ_reg  <= occ_next;
        end
    end

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (rem_reg),
        .re    (cmd.rd_issue),
        .raddr (cnt_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    // output buffer: head word is on the port, tail word catches a stalled read
    assign push_word = {pend_last_reg, digit_to_ascii(ram_rdata)};

    always_comb begin
        occ_next = occ_reg;
        if (pend_reg && !pop) begin
            occ_next = occ_reg + 2'd1;
        end else if (!pend_reg && pop) begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (occ_reg)
            2'd0: begin
                if (pend_reg) begin
                    head_reg <= push_word;
                end
            end
            2'd1: begin
                if (pend_reg && pop) begin
                    head_reg <= push_word;
                end else if (pend_reg) begin
                    tail_reg <= push_word;
                end
            end
            default: begin
                if (pop) begin
                    head_reg <= tail_reg;
                    if (pend_reg) begin
                        tail_reg <= push_word;
                    end
                end
            end
        endcase
    end

    assign occ_after_pop = occ_reg - {1'b0, pop};
    assign level         = {1'b0, occ_after_pop} + {2'b00, pend_reg};

    assign stat.div_last  = (step_reg == SW'(DIV_CYCLES - 1));
    assign stat.quot_zero = (w_reg == '0);
    assign stat.can_issue = (level < 3'd2);
    assign stat.rd_last   = (cnt_reg == CW'(1));

    assign out_valid = (occ_reg != 2'd0);
    assign out_char  = head_reg[CHAR_W-1:0];
    assign out_last  = head_reg[CHAR_W];

    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> (cnt_reg < CW'(VALUE_BITS)))
        else $error("digit stack overflow");

    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (cnt_reg != '0))
        else $error("read from empty digit stack");

    a_buf_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && occ_reg == 2'd2) |-> pop)
        else $error("output buffer overrun");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg != 2'd3)
        else $error("output buffer count out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/rdc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: load, repeated divide and store per digit, then stack readout.
// ----------------------------------------------------------------------------
module rdc_ctrl
    import rdc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    output rdc_cmd_t       cmd,
    input  wire rdc_stat_t stat
);

    rdc_state_t state_reg;
    rdc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                // quotient of zero means this remainder was the top digit
                state_next = stat.quot_zero ? ST_EMIT : ST_DIV;
            end
            ST_EMIT: begin
                cmd.rd_issue = stat.can_issue;
                if (stat.can_issue && stat.rd_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/radix_digit_converter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned value to ASCII digits in radix 2..16, most significant
// digit first, one word per digit, tlast on the final digit.
// ----------------------------------------------------------------------------
//  channel | dir | tdata bits (low first)              | tlast
//  s_      | in  | value[31:0], radix[36:32], zero pad | -
//  m_      | out | digit_char[6:0], zero pad           | last digit
//
//  each digit passes through the shared radix divider (8 quotient bits per
//  cycle) and then a stack write; readout then streams one digit per cycle
//  from the registered digit stack while the m_ side accepts them
//  s_tready is high only while the sequencer is idle; a stalled m_ side
//  holds the readout, and the next word is taken while digits still drain
//  reset clears the sequencer and the output buffer
// ----------------------------------------------------------------------------
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0], radix[36:32]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // digit_char[6:0]
    output logic                        m_tlast
);

    rdc_cmd_t          cmd;
    rdc_stat_t         stat;
    logic [CHAR_W-1:0] out_char;

    rdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rdc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .in_radix  (s_tdata[VALUE_W +: RADIX_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_TDATA_W'(out_char);

endmodule
`default_nettype wire
